[rtl/trsmc_pkg.sv]
// ----------------------------------------------------------------------------
// trsmc_pkg
// Types and constants shared by the matrix compose pipeline and its checker.
// ----------------------------------------------------------------------------
package trsmc_pkg;

  // one input word: rotation (Q2.14), translation (Q16.16), scale (Q8.8)
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } in_word_t;

  // one result word: upper 3x4 of the affine matrix, all Q16.16
  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row0_col3;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row1_col3;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] row2_col3;
  } out_word_t;

  localparam int QPROD_W = 32;   // quaternion component product
  localparam int ROT_W   = 34;   // rotation entry, Q.28, within +-16.0
  localparam int SPROD_W = 50;   // rotation entry times scale, Q.36
  localparam int DROP    = 20;   // Q.36 to Q16.16

  localparam logic signed [ROT_W-1:0]   ONE_Q28   = ROT_W'(64'sd1 <<< 28);
  localparam logic signed [SPROD_W-1:0] HALF_DROP = SPROD_W'(64'sd1 <<< (DROP - 1));
  localparam logic signed [SPROD_W-1:0] SAT_MAX   = SPROD_W'(64'sd2147483647);
  localparam logic signed [SPROD_W-1:0] SAT_MIN   = SPROD_W'(-64'sd2147483648);

endpackage

[rtl/trs_matrix_compose.sv]
// ----------------------------------------------------------------------------
// trs_matrix_compose
// Quaternion, translation and per-axis scale to a 3x4 affine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one transform word: quaternion w,x,y,z
//   in Q2.14 (not normalised), position in Q16.16 and scale in Q8.8.
//   out_valid/out_stall/out_data carry the matrix rows 0..2, columns 0..3
//   in Q16.16; column c of the rotation is scaled by scale c, column 3 is
//   the position unchanged. Entries round to nearest (ties upward) and
//   saturate to the 32 bit range.
// Timing:
//   four register stages: component products, rotation entries, scale
//   products, round and saturate into the output register. An accepted word
//   passes through them in that order to out_valid. One word per cycle is
//   taken while the receiver does not stall; the nine 34x16 scale
//   multipliers in stage three set the critical path.
// Stall and reset:
//   each stage holds while the stage after it is full and stalled, so a
//   stalled receiver fills the pipe and then raises in_stall; nothing is
//   dropped or repeated. Reset empties all stages.
// ----------------------------------------------------------------------------
module trs_matrix_compose (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trsmc_pkg::in_word_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trsmc_pkg::out_word_t out_data
);

  localparam int QW = trsmc_pkg::QPROD_W;
  localparam int RW = trsmc_pkg::ROT_W;
  localparam int SW = trsmc_pkg::SPROD_W;

  // stage valids and readiness
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: component products
  logic signed [QW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [15:0]   s1_scale_r [3];
  logic signed [31:0]   s1_pos_r   [3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx_r <= in_data.quat_x * in_data.quat_x;
      yy_r <= in_data.quat_y * in_data.quat_y;
      zz_r <= in_data.quat_z * in_data.quat_z;
      xy_r <= in_data.quat_x * in_data.quat_y;
      xz_r <= in_data.quat_x * in_data.quat_z;
      yz_r <= in_data.quat_y * in_data.quat_z;
      wx_r <= in_data.quat_w * in_data.quat_x;
      wy_r <= in_data.quat_w * in_data.quat_y;
      wz_r <= in_data.quat_w * in_data.quat_z;
      s1_scale_r[0] <= in_data.scale_x;
      s1_scale_r[1] <= in_data.scale_y;
      s1_scale_r[2] <= in_data.scale_z;
      s1_pos_r[0]   <= in_data.pos_x;
      s1_pos_r[1]   <= in_data.pos_y;
      s1_pos_r[2]   <= in_data.pos_z;
    end
  end

  // stage 2: rotation entries in Q.28, row-major
  logic signed [RW-1:0] rot_nxt [9];
  logic signed [RW-1:0] rot_r   [9];
  logic signed [15:0]   s2_scale_r [3];
  logic signed [31:0]   s2_pos_r   [3];

  function automatic logic signed [RW-1:0] ext(input logic signed [QW-1:0] v);
    return RW'(v);
  endfunction

  always_comb begin
    rot_nxt[0] = trsmc_pkg::ONE_Q28 - ((ext(yy_r) + ext(zz_r)) <<< 1);
    rot_nxt[1] = (ext(xy_r) - ext(wz_r)) <<< 1;
    rot_nxt[2] = (ext(xz_r) + ext(wy_r)) <<< 1;
    rot_nxt[3] = (ext(xy_r) + ext(wz_r)) <<< 1;
    rot_nxt[4] = trsmc_pkg::ONE_Q28 - ((ext(xx_r) + ext(zz_r)) <<< 1);
    rot_nxt[5] = (ext(yz_r) - ext(wx_r)) <<< 1;
    rot_nxt[6] = (ext(xz_r) - ext(wy_r)) <<< 1;
    rot_nxt[7] = (ext(yz_r) + ext(wx_r)) <<< 1;
    rot_nxt[8] = trsmc_pkg::ONE_Q28 - ((ext(xx_r) + ext(yy_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rot_r      <= rot_nxt;
      s2_scale_r <= s1_scale_r;
      s2_pos_r   <= s1_pos_r;
    end
  end

  // stage 3: entry times column scale, Q.36
  logic signed [SW-1:0] sprod_r [9];
  logic signed [31:0]   s3_pos_r [3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 9; i++) begin
        sprod_r[i] <= rot_r[i] * s2_scale_r[i % 3];
      end
      s3_pos_r <= s2_pos_r;
    end
  end

  // stage 4: round to Q16.16 and saturate
  logic signed [31:0] ent_nxt [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      logic signed [SW-1:0] t;
      t = (sprod_r[i] + trsmc_pkg::HALF_DROP) >>> trsmc_pkg::DROP;
      if (t > trsmc_pkg::SAT_MAX) begin
        ent_nxt[i] = 32'sh7fff_ffff;
      end else if (t < trsmc_pkg::SAT_MIN) begin
        ent_nxt[i] = 32'sh8000_0000;
      end else begin
        ent_nxt[i] = t[31:0];
      end
    end
  end

  trsmc_pkg::out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_data_r.row0_col0 <= ent_nxt[0];
      out_data_r.row0_col1 <= ent_nxt[1];
      out_data_r.row0_col2 <= ent_nxt[2];
      out_data_r.row0_col3 <= s3_pos_r[0];
      out_data_r.row1_col0 <= ent_nxt[3];
      out_data_r.row1_col1 <= ent_nxt[4];
      out_data_r.row1_col2 <= ent_nxt[5];
      out_data_r.row1_col3 <= s3_pos_r[1];
      out_data_r.row2_col0 <= ent_nxt[6];
      out_data_r.row2_col1 <= ent_nxt[7];
      out_data_r.row2_col2 <= ent_nxt[8];
      out_data_r.row2_col3 <= s3_pos_r[2];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/trsmc_checker.sv]
// ----------------------------------------------------------------------------
// trsmc_checker
// Port-level checks on the matrix compose pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module trsmc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input trsmc_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input trsmc_pkg::out_word_t out_data
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // back-pressure only arises from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // with no output stall an accepted word comes out, x and z translation intact
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid && out_data.row0_col3 == $past(in_data.pos_x, 4)
        && out_data.row2_col3 == $past(in_data.pos_z, 4))
    else $error("result word missing or translation wrong");

  // the output empties only after a word is taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result word dropped");

endmodule

bind trs_matrix_compose trsmc_checker u_trsmc_checker (.*);

[tb/sv/tb_trs_matrix_compose.sv]
// ----------------------------------------------------------------------------
// tb_trs_matrix_compose
// Self-checking bench for the quaternion/translation/scale matrix composer.
// Every accepted transform word is turned into its expected 3x4 matrix by a
// bit-exact predictor and queued in a scoreboard; each result word leaving
// the block is checked entry by entry against the oldest queued matrix.
// Directed corner words come first, then randomised words, with random
// gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_trs_matrix_compose;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam longint      ROT_UNITY    = 64'sd1 <<< 28;
  localparam longint      ROUND_HALF   = 64'sd1 <<< 19;
  localparam int          ROUND_SHIFT  = 20;
  localparam longint      Q16_MAX      = 64'sd2147483647;
  localparam longint      Q16_MIN      = -64'sd2147483648;

  // random word flavours
  typedef enum int {
    MIX_RAW,
    MIX_UNIT,
    MIX_POW2,
    MIX_CORNER
  } word_mix_t;

  class matrix_scoreboard;
    trsmc_pkg::out_word_t expected_q[$];
    int unsigned          error_cnt;

    function new();
      error_cnt = 0;
    endfunction

    // rotation matrix in Q.28, times scale in Q.36, round half up to Q16.16
    static function trsmc_pkg::out_word_t compose_matrix(trsmc_pkg::in_word_t w);
      longint            qw, qx, qy, qz, prod, rnd;
      longint            rot[3][3];
      longint            scl[3];
      logic [31:0]       pos[3];
      logic [11:0][31:0] flat;
      qw     = w.quat_w;
      qx     = w.quat_x;
      qy     = w.quat_y;
      qz     = w.quat_z;
      scl[0] = w.scale_x;
      scl[1] = w.scale_y;
      scl[2] = w.scale_z;
      pos[0] = w.pos_x;
      pos[1] = w.pos_y;
      pos[2] = w.pos_z;
      rot[0][0] = ROT_UNITY - 2 * (qy * qy + qz * qz);
      rot[0][1] = 2 * (qx * qy - qw * qz);
      rot[0][2] = 2 * (qx * qz + qw * qy);
      rot[1][0] = 2 * (qx * qy + qw * qz);
      rot[1][1] = ROT_UNITY - 2 * (qx * qx + qz * qz);
      rot[1][2] = 2 * (qy * qz - qw * qx);
      rot[2][0] = 2 * (qx * qz - qw * qy);
      rot[2][1] = 2 * (qy * qz + qw * qx);
      rot[2][2] = ROT_UNITY - 2 * (qx * qx + qy * qy);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod = rot[r][c] * scl[c];
          rnd  = (prod + ROUND_HALF) >>> ROUND_SHIFT;
          if (rnd > Q16_MAX) rnd = Q16_MAX;
          if (rnd < Q16_MIN) rnd = Q16_MIN;
          flat[11 - (r * 4 + c)] = rnd[31:0];
        end
        flat[11 - (r * 4 + 3)] = pos[r];
      end
      return trsmc_pkg::out_word_t'(flat);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      error_cnt++;
    endtask

    function void note_input(trsmc_pkg::in_word_t w);
      expected_q.push_back(compose_matrix(w));
    endfunction

    task check_result(trsmc_pkg::out_word_t got);
      trsmc_pkg::out_word_t want;
      logic [11:0][31:0]    got_f;
      logic [11:0][31:0]    want_f;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing queued: %h", got));
        return;
      end
      want   = expected_q.pop_front();
      got_f  = got;
      want_f = want;
      for (int k = 0; k < 12; k++) begin
        if (got_f[11 - k] !== want_f[11 - k]) begin
          report_mismatch($sformatf("row%0d_col%0d got %h expected %h",
                                    k / 4, k % 4, got_f[11 - k], want_f[11 - k]));
        end
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  trsmc_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  trsmc_pkg::out_word_t out_data;

  matrix_scoreboard sb;

  always #5 clk = ~clk;

  trs_matrix_compose u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // both handshakes are sampled at the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_input(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
    end
  end

  // receiver stalls: mostly short, now and then long, often none at all
  initial begin : rx_stall_gen
    int unsigned seg;
    int unsigned pick;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      pick = $urandom_range(0, 19);
      if (pick < 12) seg = $urandom_range(1, 3);
      else if (pick < 14) seg = $urandom_range(15, 60);
      else seg = 0;
      repeat (seg) begin
        @(posedge clk);
        out_stall <= 1'b1;
      end
      seg = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      repeat (seg) begin
        @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic trsmc_pkg::in_word_t make_word(logic [15:0] qw, logic [15:0] qx,
                                                    logic [15:0] qy, logic [15:0] qz,
                                                    logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz, logic [15:0] sx,
                                                    logic [15:0] sy, logic [15:0] sz);
    trsmc_pkg::in_word_t w;
    w.quat_w  = qw;
    w.quat_x  = qx;
    w.quat_y  = qy;
    w.quat_z  = qz;
    w.pos_x   = px;
    w.pos_y   = py;
    w.pos_z   = pz;
    w.scale_x = sx;
    w.scale_y = sy;
    w.scale_z = sz;
    return w;
  endfunction

  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] corner32();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // small mantissa shifted up, so products land near the rounding point
  function automatic logic [15:0] pow2_val(int unsigned max_shift);
    return 16'((int'($urandom_range(0, 15)) - 8) <<< $urandom_range(0, max_shift));
  endfunction

  function automatic trsmc_pkg::in_word_t random_word();
    trsmc_pkg::in_word_t w;
    word_mix_t           mix;
    mix = word_mix_t'($urandom_range(0, 99) < 40 ? MIX_RAW :
                      $urandom_range(0, 99) < 50 ? MIX_UNIT :
                      $urandom_range(0, 1) == 0 ? MIX_POW2 : MIX_CORNER);
    case (mix)
      MIX_RAW: begin
        w = make_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom, $urandom, $urandom,
                      16'($urandom), 16'($urandom), 16'($urandom));
      end
      MIX_UNIT: begin
        w = make_word(16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
                      16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
                      $urandom, $urandom, $urandom,
                      16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
                      16'($urandom_range(0, 4095) - 2048));
      end
      MIX_POW2: begin
        w = make_word(pow2_val(10), pow2_val(10), pow2_val(10), pow2_val(10),
                      corner32(), corner32(), corner32(),
                      pow2_val(4), pow2_val(4), pow2_val(4));
      end
      default: begin
        w = make_word(corner16(), corner16(), corner16(), corner16(),
                      corner32(), corner32(), corner32(),
                      corner16(), corner16(), corner16());
      end
    endcase
    return w;
  endfunction

  task automatic send_word(trsmc_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic sender_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 65) n = 0;
    else if (pick < 94) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // let the current edge pass first so the word taken at it is already queued
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    trsmc_pkg::in_word_t directed_q[$];
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity rotation, unit scale
    directed_q.push_back(make_word(16'd16384, 16'd0, 16'd0, 16'd0,
                                   32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
                                   16'd256, 16'd256, 16'd256));
    directed_q.push_back(make_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    directed_q.push_back(make_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   16'h7fff, 16'h7fff, 16'h7fff));
    directed_q.push_back(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   16'h8000, 16'h8000, 16'h8000));
    directed_q.push_back(make_word(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                                   32'hffff_ffff, 32'h0000_0001, 32'h0,
                                   16'h8000, 16'h7fff, 16'h8000));
    // half turns about each axis and a quarter turn about z
    directed_q.push_back(make_word(16'd0, 16'd16384, 16'd0, 16'd0, '0, '0, '0,
                                   16'd256, 16'd256, 16'd256));
    directed_q.push_back(make_word(16'd0, 16'd0, 16'd16384, 16'd0, '0, '0, '0,
                                   16'd256, 16'd256, 16'd256));
    directed_q.push_back(make_word(16'd0, 16'd0, 16'd0, 16'd16384, '0, '0, '0,
                                   16'd256, 16'd256, 16'd256));
    directed_q.push_back(make_word(16'd11585, 16'd0, 16'd0, 16'd11585,
                                   32'h0010_8000, 32'hffef_8000, 32'h0,
                                   16'd256, 16'd512, 16'd128));
    // quaternion of norm two, not normalised so the matrix carries shear
    directed_q.push_back(make_word(16'd16384, 16'd16384, 16'd16384, 16'd16384, '0, '0, '0,
                                   16'd256, 16'd256, 16'd256));
    directed_q.push_back(make_word(16'h7fff, 16'd0, 16'd0, 16'd0, '0, '0, '0,
                                   16'd256, 16'd256, 16'd256));
    // zero and negative scales
    directed_q.push_back(make_word(16'd16384, 16'd0, 16'd0, 16'd0,
                                   32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                   16'd0, 16'd0, 16'd0));
    directed_q.push_back(make_word(16'd16384, 16'd0, 16'd0, 16'd0, '0, '0, '0,
                                   16'hff00, 16'hfe00, 16'hff80));
    // exact halfway cases, positive and negative, and just off halfway
    directed_q.push_back(make_word(16'd0, 16'd512, 16'd512, 16'd0, '0, '0, '0,
                                   16'd1, 16'd1, 16'd1));
    directed_q.push_back(make_word(16'd0, 16'd512, 16'd512, 16'd0, '0, '0, '0,
                                   16'hffff, 16'hffff, 16'hffff));
    directed_q.push_back(make_word(16'd0, 16'd768, 16'd512, 16'd0, '0, '0, '0,
                                   16'd1, 16'd1, 16'd1));
    directed_q.push_back(make_word(16'd0, 16'd768, 16'd512, 16'd0, '0, '0, '0,
                                   16'hffff, 16'hffff, 16'hffff));
    directed_q.push_back(make_word(16'd0, 16'd513, 16'd511, 16'd1, '0, '0, '0,
                                   16'd1, 16'hffff, 16'd3));
    // largest magnitude the field widths allow
    directed_q.push_back(make_word(16'd0, 16'h8000, 16'h8000, 16'h8000,
                                   32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                   16'h8000, 16'h8000, 16'h8000));
    directed_q.push_back(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, '0, '0,
                                   16'h7fff, 16'h7fff, 16'h7fff));

    foreach (directed_q[i]) begin
      send_word(directed_q[i]);
      sender_gap();
    end

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_word());
      sender_gap();
      // let the pipe run empty now and then
      if (n == 150 || n == 400) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
